// ----- hdl/tia_pkg.sv -----
package tia_pkg;

    // sizes
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int INDEX_BITS_DEF  = 27;
    localparam int TYPE_COUNT      = 32;
    localparam int TYPE_W          = 5;
    localparam int NID_W           = 32;
    localparam int CNT_W           = 28;
    localparam int COUNT_W         = 11;
    localparam int FUNC_W          = 2;
    localparam int RES_N           = 14;

    // per-type counter start values
    localparam logic [CNT_W-1:0] IDX_START_LOW  = 28'h000_0001;
    localparam logic [CNT_W-1:0] IDX_START_USER = 28'h000_0400;

    // valid type ranges
    localparam logic [TYPE_W-1:0] TYPE_ROOT    = 5'h00;
    localparam logic [TYPE_W-1:0] TYPE_A_LO    = 5'h01;
    localparam logic [TYPE_W-1:0] TYPE_A_HI    = 5'h08;
    localparam logic [TYPE_W-1:0] TYPE_B_LO    = 5'h0A;
    localparam logic [TYPE_W-1:0] TYPE_B_HI    = 5'h13;
    localparam logic [TYPE_W-1:0] TYPE_LAST    = 5'h1F;

    // identifiers that are in use from reset on
    localparam logic [NID_W-1:0] RESERVED_IDS [RES_N] = '{
        32'h0000_0021, 32'h0000_0061, 32'h0000_00A1, 32'h0000_00C1,
        32'h0000_0122, 32'h0000_01E1, 32'h0000_0201, 32'h0000_0241,
        32'h0000_0261, 32'h0000_0281, 32'h0000_02A1, 32'h0000_02E1,
        32'h0000_0301, 32'h0000_0321
    };

    // request codes
    localparam logic [FUNC_W-1:0] FN_ALLOC    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY    = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_TYPE  = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_START,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             start;
        logic             append;
        logic [NID_W-1:0] key;
    } tbl_req_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } tbl_rsp_t;

    function automatic logic type_ok(input logic [TYPE_W-1:0] t);
        return t inside {TYPE_ROOT, [TYPE_A_LO:TYPE_A_HI], [TYPE_B_LO:TYPE_B_HI], TYPE_LAST};
    endfunction

    function automatic logic is_reserved(input logic [NID_W-1:0] id);
        logic r;
        r = 1'b0;
        for (int i = 0; i < RES_N; i++)
        begin
            r = r | (id == RESERVED_IDS[i]);
        end
        return r;
    endfunction

endpackage

// ----- hdl/tia_table.sv -----
module tia_table #(
    parameter int TABLE_DEPTH = tia_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tia_pkg::tbl_req_t                   req,
    output tia_pkg::tbl_rsp_t                   rsp,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    count
);
    import tia_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] SCAN_START = CW'(RES_N);

    // entries below RES_N stay unused: reserved ids are matched against constants
    logic [NID_W-1:0] mem [TABLE_DEPTH];
    logic [NID_W-1:0] rd_data_reg;

    logic [CW-1:0] count_reg,     count_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic          busy_reg,      busy_next;
    logic          pend_reg,      pend_next;
    logic          res_hit_reg,   res_hit_next;

    logic issue;
    logic mem_hit;
    logic done;
    logic full;
    logic do_append;

    assign full      = (count_reg >= DEPTH_C);
    assign issue     = busy_reg && (scan_addr_reg < count_reg);
    assign mem_hit   = pend_reg && (rd_data_reg == req.key);
    assign done      = busy_reg && (res_hit_reg || mem_hit || !issue);
    assign do_append = req.append && !full;

    always_comb
    begin
        busy_next      = busy_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = 1'b0;
        res_hit_next   = res_hit_reg;
        count_next     = count_reg;
        if (req.start)
        begin
            busy_next      = 1'b1;
            scan_addr_next = SCAN_START;
            res_hit_next   = is_reserved(req.key);
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            else if (issue)
            begin
                scan_addr_next = scan_addr_reg + CW'(1);
                pend_next      = 1'b1;
            end
        end
        if (do_append)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= SCAN_START;
            scan_addr_reg <= '0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            res_hit_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            res_hit_reg   <= res_hit_next;
        end
    end

    // one read port for the scan, one write port for appends
    always_ff @(posedge clk)
    begin
        if (issue && !done)
        begin
            rd_data_reg <= mem[scan_addr_reg[AW-1:0]];
        end
        if (do_append)
        begin
            mem[count_reg[AW-1:0]] <= req.key;
        end
    end

    assign rsp.done = done;
    assign rsp.hit  = res_hit_reg || mem_hit;
    assign rsp.full = full;
    assign count    = count_reg;

endmodule

// ----- hdl/typed_id_allocator.sv -----
// Flow: register and query go through decode, start and one table scan to the result;
//   an allocate adds a load step and one table scan for each index it probes.
// Throughput: one request at a time, next transfer in the cycle after the result is loaded; the
//   scan reads one used-id entry per cycle.
// Reset: asynchronous, active low; counters, fill count and control take their reset values at
//   once, the reserved ids are held as constants, so no clearing pass is needed.
module typed_id_allocator #(
    parameter int TABLE_DEPTH = tia_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX_BITS  = tia_pkg::INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tia_pkg::FUNC_W-1:0]   func,
    input  logic [tia_pkg::TYPE_W-1:0]   nid_type,
    input  logic [tia_pkg::NID_W-1:0]    nid_value,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tia_pkg::NID_W-1:0]    nid_out,
    output logic [2:0]                   status,
    output logic                         is_allocated,
    output logic [tia_pkg::COUNT_W-1:0]  allocated_count
);
    import tia_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] IDX_LIMIT = CNT_W'(1) << INDEX_BITS;

    state_t state_reg, state_next;

    // latched request
    logic [FUNC_W-1:0] func_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [NID_W-1:0]  value_reg;

    // identifier being looked up in the table
    logic [NID_W-1:0]  key_reg, key_next;

    // per-type next index
    logic [CNT_W-1:0]  next_idx_reg [TYPE_COUNT];

    // result under construction
    logic [NID_W-1:0]  res_nid_reg,    res_nid_next;
    status_t           res_status_reg, res_status_next;
    logic              res_isal_reg,   res_isal_next;

    // output register
    logic              out_valid_reg,  out_valid_next;
    logic [NID_W-1:0]  out_nid_reg;
    status_t           out_status_reg;
    logic              out_isal_reg;
    logic [COUNT_W-1:0] out_count_reg;

    tbl_req_t          tbl_req;
    tbl_rsp_t          tbl_rsp;
    logic [CW-1:0]     tbl_count;

    logic              in_xfer;
    logic              out_load;
    logic              idx_bump;
    logic [CNT_W-1:0]  idx_rd;
    logic              idx_ok;
    logic [NID_W-1:0]  cand;
    logic              is_alloc;

    tia_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp),
        .count (tbl_count)
    );

    // counter read and candidate id; counter below the limit, so the shift drops nothing
    assign idx_rd   = next_idx_reg[type_reg];
    assign idx_ok   = (idx_rd < IDX_LIMIT);
    assign cand     = (NID_W'(idx_rd) << TYPE_W) | NID_W'(type_reg);
    assign is_alloc = (func_reg == FN_ALLOC);
    assign in_xfer  = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (func_reg)
                    FN_ALLOC:
                    begin
                        if (!type_ok(type_reg) || tbl_rsp.full)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_LOAD;
                        end
                    end
                    FN_REGISTER:
                    begin
                        if (!type_ok(value_reg[TYPE_W-1:0]))
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_START;
                        end
                    end
                    FN_QUERY:
                    begin
                        state_next = S_START;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_LOAD:
            begin
                state_next = idx_ok ? S_START : S_RESP;
            end
            S_START:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (tbl_rsp.done)
                begin
                    // an allocate that hits a used id tries the next index
                    state_next = (is_alloc && tbl_rsp.hit) ? S_LOAD : S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready        = (state_reg == S_IDLE);
        tbl_req.start   = (state_reg == S_START);
        tbl_req.key     = key_reg;
        tbl_req.append  = (state_reg == S_SCAN) && tbl_rsp.done && !tbl_rsp.hit &&
                          (is_alloc || (func_reg == FN_REGISTER));
        idx_bump        = (state_reg == S_LOAD) && idx_ok;
        out_load        = (state_reg == S_RESP) && (!out_valid_reg || out_ready);
        out_valid_next  = out_load || (out_valid_reg && !out_ready);
    end

    // result and key datapath
    always_comb
    begin
        key_next        = key_reg;
        res_nid_next    = res_nid_reg;
        res_status_next = res_status_reg;
        res_isal_next   = res_isal_reg;
        case (state_reg)
            S_IDLE:
            begin
                res_nid_next    = '0;
                res_status_next = ST_OK;
                res_isal_next   = 1'b0;
            end
            S_DECODE:
            begin
                key_next = value_reg;
                if (is_alloc)
                begin
                    if (!type_ok(type_reg))
                    begin
                        res_status_next = ST_BAD_TYPE;
                    end
                    else if (tbl_rsp.full)
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                else if (func_reg == FN_REGISTER)
                begin
                    if (!type_ok(value_reg[TYPE_W-1:0]))
                    begin
                        res_status_next = ST_BAD_TYPE;
                    end
                end
            end
            S_LOAD:
            begin
                key_next = cand;
                if (!idx_ok)
                begin
                    res_status_next = ST_EXHAUSTED;
                end
            end
            S_SCAN:
            begin
                if (tbl_rsp.done)
                begin
                    case (func_reg)
                        FN_ALLOC:
                        begin
                            if (!tbl_rsp.hit)
                            begin
                                res_nid_next = key_reg;
                            end
                        end
                        FN_REGISTER:
                        begin
                            if (tbl_rsp.hit)
                            begin
                                res_status_next = ST_DUPLICATE;
                            end
                            else if (tbl_rsp.full)
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        FN_QUERY:
                        begin
                            res_isal_next = tbl_rsp.hit;
                        end
                        default:
                        begin
                            res_isal_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TYPE_COUNT; i++)
            begin
                next_idx_reg[i] <= (i < 2) ? IDX_START_LOW : IDX_START_USER;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (idx_bump)
            begin
                // steps over used ids stick, even if the request later runs out of indices
                next_idx_reg[type_reg] <= idx_rd + CNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg  <= func;
            type_reg  <= nid_type;
            value_reg <= nid_value;
        end
        key_reg        <= key_next;
        res_nid_reg    <= res_nid_next;
        res_status_reg <= res_status_next;
        res_isal_reg   <= res_isal_next;
        if (out_load)
        begin
            out_nid_reg    <= res_nid_reg;
            out_status_reg <= res_status_reg;
            out_isal_reg   <= res_isal_reg;
            out_count_reg  <= COUNT_W'(tbl_count);
        end
    end

    assign out_valid       = out_valid_reg;
    assign nid_out         = out_nid_reg;
    assign status          = 3'(out_status_reg);
    assign is_allocated    = out_isal_reg;
    assign allocated_count = out_count_reg;

endmodule

// ----- hdl/tia_checker.sv -----
module tia_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tia_pkg::NID_W-1:0]    nid_out,
    input logic [2:0]                   status,
    input logic                         is_allocated,
    input logic [tia_pkg::COUNT_W-1:0]  allocated_count
);
    import tia_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nid_out) && $stable(status)
            && $stable(is_allocated) && $stable(allocated_count))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_BAD_TYPE) || (status == ST_EXHAUSTED)
            || (status == ST_DUPLICATE) || (status == ST_FULL))
        else $error("status code out of range");

    // an id comes out only on a successful allocate
    a_nid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (nid_out != 32'd0) |-> (status == ST_OK) && !is_allocated)
        else $error("id returned with failure or query answer");

endmodule

bind typed_id_allocator tia_checker u_tia_checker (.*);

// ----- sim/typed_id_allocator_tb.sv -----
module typed_id_allocator_tb;

    import tia_pkg::*;

    // ------------------------------------------------------------------
    // Run sizing
    // ------------------------------------------------------------------
    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RAND_N       = 485;     // random requests after the directed rows
    localparam int TAIL_N       = 30;      // random requests at the end, no idling
    localparam int HOLD_AT      = 150;     // transfers in before the long output stall
    localparam int HOLD_CYCLES  = 3000;    // longer than one full-table probe
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int LIMIT_CYCLES = 8_000_000;

    // func value with no meaning; block answers with an empty result
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    // counter values at or above this are out of index space
    localparam logic [CNT_W-1:0] IDX_LIMIT = CNT_W'(1) << INDEX_BITS_DEF;

    typedef struct packed {
        logic [NID_W-1:0]   nid;
        status_t            st;
        logic               isal;
        logic [COUNT_W-1:0] cnt;
    } id_reply_t;

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [TYPE_W-1:0] ty;
        logic [NID_W-1:0]  val;
        logic              typed;   // reply below is written out by hand
        id_reply_t         rep;
    } dir_row_t;

    localparam int DIR_N = 25;

    // Directed opening. Count starts at 14 (reserved ids). Rows with typed = 0
    // are left to the allocator model.
    localparam dir_row_t DIR_TBL [DIR_N] = '{
        // queries right after reset: reserved hit, all-zero and all-one misses
        '{FN_QUERY,    5'd0,  32'h0000_0021, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd14}},
        '{FN_QUERY,    5'd0,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd14}},
        '{FN_QUERY,    5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd14}},
        // low types start at index 1; type 1 has to step over reserved ids
        '{FN_ALLOC,    5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0020, ST_OK,        1'b0, 11'd15}},
        '{FN_ALLOC,    5'd1,  32'h0000_0000, 1'b1, '{32'h0000_0041, ST_OK,        1'b0, 11'd16}},
        '{FN_ALLOC,    5'd1,  32'h0000_0000, 1'b1, '{32'h0000_0081, ST_OK,        1'b0, 11'd17}},
        '{FN_ALLOC,    5'd1,  32'h0000_0000, 1'b0, '{32'h0000_0000, ST_OK,        1'b0, 11'd0}},
        // holes in the type map
        '{FN_ALLOC,    5'd9,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_BAD_TYPE,  1'b0, 11'd18}},
        '{FN_ALLOC,    5'd20, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_BAD_TYPE,  1'b0, 11'd18}},
        // user types start at 0x400
        '{FN_ALLOC,    5'd31, 32'h0000_0000, 1'b1, '{32'h0000_801F, ST_OK,        1'b0, 11'd19}},
        '{FN_ALLOC,    5'd19, 32'h0000_0000, 1'b1, '{32'h0000_8013, ST_OK,        1'b0, 11'd20}},
        // register the next type-5 id, then allocate over it
        '{FN_REGISTER, 5'd31, 32'h0000_8005, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd21}},
        '{FN_ALLOC,    5'd5,  32'h0000_0000, 1'b0, '{32'h0000_0000, ST_OK,        1'b0, 11'd0}},
        '{FN_REGISTER, 5'd0,  32'h0000_8005, 1'b1, '{32'h0000_0000, ST_DUPLICATE, 1'b0, 11'd22}},
        '{FN_REGISTER, 5'd0,  32'h0000_0021, 1'b1, '{32'h0000_0000, ST_DUPLICATE, 1'b0, 11'd22}},
        '{FN_REGISTER, 5'd0,  32'hFFFF_FFE9, 1'b1, '{32'h0000_0000, ST_BAD_TYPE,  1'b0, 11'd22}},
        '{FN_REGISTER, 5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd23}},
        '{FN_REGISTER, 5'd31, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd24}},
        '{FN_QUERY,    5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd24}},
        // spare func code: empty result, count only
        '{FN_SPARE,    5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd24}},
        '{FN_SPARE,    5'd0,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd24}},
        '{FN_QUERY,    5'd0,  32'h0000_8025, 1'b0, '{32'h0000_0000, ST_OK,        1'b0, 11'd0}},
        '{FN_ALLOC,    5'd2,  32'h0000_0000, 1'b0, '{32'h0000_0000, ST_OK,        1'b0, 11'd0}},
        '{FN_REGISTER, 5'd0,  32'hFFFF_FFF4, 1'b1, '{32'h0000_0000, ST_BAD_TYPE,  1'b0, 11'd25}},
        '{FN_REGISTER, 5'd0,  32'h7FFF_FFE0, 1'b0, '{32'h0000_0000, ST_OK,        1'b0, 11'd0}}
    };

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [FUNC_W-1:0]  func;
    logic [TYPE_W-1:0]  nid_type;
    logic [NID_W-1:0]   nid_value;
    logic               out_valid;
    logic               out_ready;
    logic [NID_W-1:0]   nid_out;
    logic [2:0]         status;
    logic               is_allocated;
    logic [COUNT_W-1:0] allocated_count;

    typed_id_allocator u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .nid_type        (nid_type),
        .nid_value       (nid_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .nid_out         (nid_out),
        .status          (status),
        .is_allocated    (is_allocated),
        .allocated_count (allocated_count)
    );

    // ------------------------------------------------------------------
    // Allocator model state: per-type counters and the used-id table.
    // id_list keeps insertion order (and the count), id_seen gives lookup.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] idx_ctr [TYPE_COUNT];
    logic [NID_W-1:0] id_list [$];
    bit               id_seen [logic [NID_W-1:0]];

    id_reply_t        pending_replies [$];
    bit               failed;
    int               reqs_accepted;
    int               idle_level;   // 0: no idling, 1..3: more frequent bursts
    int               cycle_cnt;

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("typed_id_allocator_tb NOT OK");
            $finish;
        end
    end

    function automatic bit legal_type(input logic [TYPE_W-1:0] t);
        return (t == TYPE_ROOT) || (t == TYPE_LAST) ||
               (t >= TYPE_A_LO && t <= TYPE_A_HI) ||
               (t >= TYPE_B_LO && t <= TYPE_B_HI);
    endfunction

    // uniform over the 20 legal type codes
    function automatic logic [TYPE_W-1:0] pick_legal_type();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return TYPE_ROOT;
        if (k <= 8)
            return TYPE_W'(k);
        if (k <= 18)
            return TYPE_W'(k + 1);
        return TYPE_LAST;
    endfunction

    task automatic reset_allocator_model();
        for (int t = 0; t < TYPE_COUNT; t++)
            idx_ctr[t] = IDX_START_USER;
        idx_ctr[0] = IDX_START_LOW;
        idx_ctr[1] = IDX_START_LOW;
        id_list.delete();
        id_seen.delete();
        for (int i = 0; i < RES_N; i++)
        begin
            id_list.push_back(RESERVED_IDS[i]);
            id_seen[RESERVED_IDS[i]] = 1'b1;
        end
    endtask

    // Works out the reply to one request and updates the model state.
    task automatic predict_reply(input logic [FUNC_W-1:0] fn, input logic [TYPE_W-1:0] ty,
                                 input logic [NID_W-1:0] val, output id_reply_t rep);
        logic [CNT_W-1:0] idx;
        logic [NID_W-1:0] cand;
        bit               done;
        rep = '{nid: '0, st: ST_OK, isal: 1'b0, cnt: '0};
        case (fn)
            FN_ALLOC:
            begin
                if (!legal_type(ty))
                    rep.st = ST_BAD_TYPE;
                else if (id_list.size() >= DEPTH)
                    rep.st = ST_FULL;
                else
                begin
                    // walk the counter past ids already taken; steps stick
                    done = 1'b0;
                    while (!done)
                    begin
                        idx = idx_ctr[ty];
                        if (idx >= IDX_LIMIT)
                        begin
                            rep.st = ST_EXHAUSTED;
                            done   = 1'b1;
                        end
                        else
                        begin
                            idx_ctr[ty] = idx + 1'b1;
                            cand = {idx[INDEX_BITS_DEF-1:0], ty};
                            if (!id_seen.exists(cand))
                            begin
                                id_list.push_back(cand);
                                id_seen[cand] = 1'b1;
                                rep.nid = cand;
                                done    = 1'b1;
                            end
                        end
                    end
                end
            end
            FN_REGISTER:
            begin
                if (!legal_type(val[TYPE_W-1:0]))
                    rep.st = ST_BAD_TYPE;
                else if (id_seen.exists(val))
                    rep.st = ST_DUPLICATE;
                else if (id_list.size() >= DEPTH)
                    rep.st = ST_FULL;
                else
                begin
                    id_list.push_back(val);
                    id_seen[val] = 1'b1;
                end
            end
            FN_QUERY:
                rep.isal = id_seen.exists(val) ? 1'b1 : 1'b0;
            default:
                ;
        endcase
        rep.cnt = COUNT_W'(id_list.size());
    endtask

    // One request transfer. Optional idle burst first; valid is only raised
    // here, and lowered only for an idle burst and at the very end of stimulus.
    task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [TYPE_W-1:0] ty,
                                 input logic [NID_W-1:0] val, input bit use_typed,
                                 input id_reply_t typed_rep);
        id_reply_t rep;
        if (idle_level != 0 && $urandom_range(0, 7) < idle_level)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= fn;
        nid_type  <= ty;
        nid_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        predict_reply(fn, ty, val, rep);
        if (use_typed)
            rep = typed_rep;
        pending_replies.push_back(rep);
        reqs_accepted++;
    endtask

    // Random request mix. Registers aimed just ahead of a type counter make
    // later allocations skip; queries and duplicates draw from the table.
    task automatic draw_request(output logic [FUNC_W-1:0] fn, output logic [TYPE_W-1:0] ty,
                                output logic [NID_W-1:0] val);
        int               r;
        int               k;
        logic [TYPE_W-1:0] t;
        logic [CNT_W-1:0]  idx;
        r   = $urandom_range(0, 99);
        k   = $urandom_range(0, 99);
        ty  = TYPE_W'($urandom_range(0, 31));
        val = $urandom();
        t   = pick_legal_type();
        idx = idx_ctr[t] + CNT_W'($urandom_range(0, 3));
        if (r < 40)
        begin
            fn = FN_ALLOC;
            if (k < 85)
                ty = t;
        end
        else if (r < 65)
        begin
            fn = FN_REGISTER;
            if (k < 35)
                val = {idx[INDEX_BITS_DEF-1:0], t};
            else if (k < 55)
                val = id_list[$urandom_range(0, id_list.size() - 1)];
            else if (k >= 75)
                val[TYPE_W-1:0] = t;
        end
        else if (r < 95)
        begin
            fn = FN_QUERY;
            if (k < 50)
                val = id_list[$urandom_range(0, id_list.size() - 1)];
            else if (k < 75)
                val = {idx[INDEX_BITS_DEF-1:0] - 27'd2, t};
        end
        else
            fn = FN_SPARE;
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, one long hold-off, and checking of
    // every result transfer against the oldest expected reply.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        id_reply_t want;
        int        stall_left;
        int        hold_left;
        bit        hold_done;
        out_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected result: nid %h status %0d is_allocated %0b count %0d",
                             $time, nid_out, status, is_allocated, allocated_count);
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (nid_out !== want.nid)
                    begin
                        $display("%0t: nid_out expected %h got %h", $time, want.nid, nid_out);
                        failed = 1'b1;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.st, status);
                        failed = 1'b1;
                    end
                    if (is_allocated !== want.isal)
                    begin
                        $display("%0t: is_allocated expected %0b got %0b",
                                 $time, want.isal, is_allocated);
                        failed = 1'b1;
                    end
                    if (allocated_count !== want.cnt)
                    begin
                        $display("%0t: allocated_count expected %0d got %0d",
                                 $time, want.cnt, allocated_count);
                        failed = 1'b1;
                    end
                end
            end

            // long hold-off: block finishes its request, then stalls its input
            if (!hold_done && reqs_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_level != 0 && $urandom_range(0, 15) < idle_level)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    initial
    begin : request_side
        logic [FUNC_W-1:0] fn;
        logic [TYPE_W-1:0] ty;
        logic [NID_W-1:0]  val;
        id_reply_t         no_rep;
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FN_ALLOC;
        nid_type      = '0;
        nid_value     = '0;
        failed        = 1'b0;
        reqs_accepted = 0;
        idle_level    = 2;
        cycle_cnt     = 0;
        no_rep        = '{nid: '0, st: ST_OK, isal: 1'b0, cnt: '0};
        reset_allocator_model();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            issue_request(DIR_TBL[i].fn, DIR_TBL[i].ty, DIR_TBL[i].val,
                          DIR_TBL[i].typed, DIR_TBL[i].rep);

        // random mix; idling level changes every 30 transfers, sometimes off
        for (int n = 0; n < RAND_N; n++)
        begin
            if (n % 30 == 0)
                idle_level = $urandom_range(0, 3);
            draw_request(fn, ty, val);
            issue_request(fn, ty, val, 1'b0, no_rep);
        end

        // closing stretch without idling
        idle_level = 0;
        for (int n = 0; n < TAIL_N; n++)
        begin
            draw_request(fn, ty, val);
            issue_request(fn, ty, val, 1'b0, no_rep);
        end
        in_valid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed)
            $display("typed_id_allocator_tb OK");
        else
            $display("typed_id_allocator_tb NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tia_pkg.sv
hdl/tia_table.sv
hdl/typed_id_allocator.sv
hdl/tia_checker.sv
sim/typed_id_allocator_tb.sv
